>>> rtl/gdcs_pkg.sv
// Shared widths, gain preset codes and gain tables for the drive command shaper.
package gdcs_pkg;

  localparam int DEF_TRIG_FULL  = 1023;
  localparam int DEF_STICK_FULL = 65535;

  localparam int FRAC_W      = 16;
  localparam int Q_W         = FRAC_W + 1;
  localparam int RECIP_SHIFT = 32;
  localparam int MUL_A_W     = Q_W;
  localparam int MUL_B_W     = RECIP_SHIFT;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int CMD_W       = 15;
  localparam int GAIN_W      = 14;

  typedef logic [MUL_A_W-1:0] mul_a_t;
  typedef logic [MUL_B_W-1:0] mul_b_t;
  typedef logic [MUL_P_W-1:0] mul_p_t;
  typedef logic [Q_W-1:0]     q_t;
  typedef logic [2:0]         preset_t;
  typedef logic [GAIN_W-1:0]  gain_t;

  localparam q_t Q_ONE = q_t'(1) << FRAC_W;

  localparam preset_t PRESET_DOWN  = 3'd0;
  localparam preset_t PRESET_LEFT  = 3'd1;
  localparam preset_t PRESET_UP    = 3'd2;
  localparam preset_t PRESET_RIGHT = 3'd3;
  localparam preset_t PRESET_FULL  = 3'd4;

  // gains in hundredths of a percent
  function automatic gain_t speed_gain(input preset_t p);
    gain_t g;
    unique case (p)
      PRESET_DOWN:  g = 14'd500;
      PRESET_LEFT:  g = 14'd1000;
      PRESET_UP:    g = 14'd2000;
      PRESET_RIGHT: g = 14'd2500;
      default:      g = 14'd10000;
    endcase
    return g;
  endfunction

  function automatic gain_t steer_gain(input preset_t p);
    gain_t g;
    unique case (p)
      PRESET_DOWN:  g = 14'd3000;
      PRESET_LEFT:  g = 14'd6000;
      PRESET_UP:    g = 14'd8000;
      default:      g = 14'd10000;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/gdcs_mul.sv
// Shared registered multiplier of the drive command shaper.
module gdcs_mul import gdcs_pkg::*; (
  input  logic   clk,
  input  mul_a_t a,
  input  mul_b_t b,
  output mul_p_t p
);

  always_ff @(posedge clk) begin
    p <= mul_p_t'(a) * mul_p_t'(b);
  end

endmodule

>>> rtl/gamepad_drive_command_shaper_unit.sv
// Drive command shaper top level: sequencer around one shared multiplier.
// A connected active poll runs 10 sequencer steps, nine of them passes through the
// shared multiplier; disconnect and waiting polls go straight to the output state.
// A new poll is accepted only once the last one has left the output state, which
// holds it while out_valid is high and out_ready is low.
// Reset clears state, config registers to defaults; no clearing pass.
module gamepad_drive_command_shaper_unit import gdcs_pkg::*; #(
  parameter int TRIG_FULL  = DEF_TRIG_FULL,
  parameter int STICK_FULL = DEF_STICK_FULL
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    connected,
  input  logic                    awaiting_first,
  input  logic [9:0]              trig_forward,
  input  logic [9:0]              trig_reverse,
  input  logic [15:0]             stick_x,
  input  logic [3:0]              dpad,
  input  logic                    btn_self_right,
  input  logic                    btn_disable,
  input  logic                    btn_trim_up,
  input  logic                    btn_trim_down,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CMD_W-1:0] speed_cmd,
  output logic signed [CMD_W-1:0] steer_cmd,
  output logic                    self_right_req,
  output logic                    disable_req,
  output logic                    link_up
);

  localparam logic [15:0] TRIG_FULL_V  = 16'(TRIG_FULL);
  localparam int          STICK_HALF   = STICK_FULL / 2;
  localparam logic [15:0] STICK_HALF_V = 16'(STICK_HALF);
  localparam mul_b_t      TRIG_RECIP   = MUL_B_W'((64'd1 << RECIP_SHIFT) / TRIG_FULL);
  localparam mul_b_t      STICK_RECIP  = MUL_B_W'((64'd1 << RECIP_SHIFT) / STICK_HALF);

  localparam logic [1:0] REG_SPEED_DZ  = 2'd0;
  localparam logic [1:0] REG_STEER_DZ  = 2'd1;
  localparam logic [1:0] REG_TRIM_LIM  = 2'd2;

  localparam logic [15:0] SPEED_DZ_RST = 16'd3277;
  localparam logic [15:0] STEER_DZ_RST = 16'd5243;
  localparam logic [5:0]  TRIM_LIM_RST = 6'd40;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [3:0] STEP_FWD_MUL   = 4'd0;
  localparam logic [3:0] STEP_FWD_EST   = 4'd1;
  localparam logic [3:0] STEP_FWD_FIX   = 4'd2;
  localparam logic [3:0] STEP_REV_EST   = 4'd3;
  localparam logic [3:0] STEP_REV_FIX   = 4'd4;
  localparam logic [3:0] STEP_STK_EST   = 4'd5;
  localparam logic [3:0] STEP_STK_FIX   = 4'd6;
  localparam logic [3:0] STEP_SPEED     = 4'd7;
  localparam logic [3:0] STEP_SQUARE    = 4'd8;
  localparam logic [3:0] STEP_STEER     = 4'd9;

  logic [15:0] speed_dz, steer_dz;
  logic [5:0]  trim_lim;

  logic [1:0]  state;
  logic [3:0]  step;
  logic [15:0] t_fwd, t_rev, stick;
  logic [3:0]  dpad_r;
  logic        trim_up_r, trim_dn_r, sr_r, dis_r;
  q_t          qest, fwd, rev;

  preset_t                 preset;
  logic signed [6:0]       trim;
  logic                    link_down;
  logic signed [CMD_W-1:0] held_speed, held_steer;

  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t prod;

  logic        stick_neg, stick_sat;
  logic [15:0] stick_dist;
  logic [15:0] corr_num, corr_div;
  logic [33:0] resid;
  q_t          corr_q, q_hi, sq, tmag, tmag_dz;
  logic        speed_neg;
  q_t          smag, smag_dz;
  logic [32:0] rnd;
  logic [CMD_W-1:0]        scaled_mag;
  logic signed [CMD_W-1:0] trim_term, speed_val, steer_val;
  logic signed [7:0]       lim_s, trim_a, trim_b;
  preset_t                 preset_next;

  gdcs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_dz <= SPEED_DZ_RST;
      steer_dz <= STEER_DZ_RST;
      trim_lim <= TRIM_LIM_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPEED_DZ: speed_dz <= cfg_data;
        REG_STEER_DZ: steer_dz <= cfg_data;
        REG_TRIM_LIM: trim_lim <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign stick_neg  = stick < STICK_HALF_V;
  assign stick_dist = stick_neg ? (STICK_HALF_V - stick) : (stick - STICK_HALF_V);
  assign stick_sat  = stick_dist >= STICK_HALF_V;

  assign q_hi = prod[RECIP_SHIFT - FRAC_W +: Q_W];
  assign sq   = prod[FRAC_W +: Q_W];

  always_comb begin
    case (step)
      STEP_FWD_FIX: begin
        corr_num = t_fwd;
        corr_div = TRIG_FULL_V;
      end
      STEP_REV_FIX: begin
        corr_num = t_rev;
        corr_div = TRIG_FULL_V;
      end
      default: begin
        corr_num = stick_dist;
        corr_div = STICK_HALF_V;
      end
    endcase
  end

  assign resid   = {2'b00, corr_num, 16'b0} - prod[33:0];
  assign corr_q  = qest + q_t'(resid >= {18'b0, corr_div});
  assign tmag    = stick_sat ? Q_ONE : corr_q;
  assign tmag_dz = (tmag < {1'b0, steer_dz}) ? '0 : tmag;

  assign speed_neg = rev < fwd;
  assign smag      = speed_neg ? (fwd - rev) : (rev - fwd);
  assign smag_dz   = (smag < {1'b0, speed_dz}) ? '0 : smag;

  assign rnd        = prod[32:0] + 33'd32768;
  assign scaled_mag = rnd[FRAC_W +: CMD_W];
  assign trim_term  = CMD_W'(trim) * 15'sd50;
  assign speed_val  = (speed_neg ? -$signed(scaled_mag) : $signed(scaled_mag)) + trim_term;
  assign steer_val  = stick_neg ? -$signed(scaled_mag) : $signed(scaled_mag);

  always_comb begin
    case (step)
      STEP_FWD_MUL: begin
        mul_a = mul_a_t'(t_fwd);
        mul_b = TRIG_RECIP;
      end
      STEP_FWD_EST, STEP_REV_EST: begin
        mul_a = q_hi;
        mul_b = mul_b_t'(TRIG_FULL_V);
      end
      STEP_FWD_FIX: begin
        mul_a = mul_a_t'(t_rev);
        mul_b = TRIG_RECIP;
      end
      STEP_REV_FIX: begin
        mul_a = mul_a_t'(stick_dist);
        mul_b = STICK_RECIP;
      end
      STEP_STK_EST: begin
        mul_a = q_hi;
        mul_b = mul_b_t'(STICK_HALF_V);
      end
      STEP_STK_FIX: begin
        mul_a = smag_dz;
        mul_b = mul_b_t'(speed_gain(preset));
      end
      STEP_SPEED: begin
        mul_a = qest;
        mul_b = mul_b_t'(qest);
      end
      STEP_SQUARE: begin
        mul_a = sq;
        mul_b = mul_b_t'(steer_gain(preset));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    lim_s  = $signed({2'b00, trim_lim});
    trim_a = 8'(trim);
    if (trim_up_r && trim_a < lim_s) trim_a = trim_a + 8'sd1;
    trim_b = trim_a;
    if (trim_dn_r && trim_b > -lim_s) trim_b = trim_b - 8'sd1;
    if (dpad_r[3])      preset_next = PRESET_RIGHT;
    else if (dpad_r[2]) preset_next = PRESET_UP;
    else if (dpad_r[1]) preset_next = PRESET_LEFT;
    else if (dpad_r[0]) preset_next = PRESET_DOWN;
    else                preset_next = preset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= STEP_FWD_MUL;
      preset     <= PRESET_FULL;
      trim       <= '0;
      link_down  <= 1'b1;
      held_speed <= '0;
      held_steer <= '0;
      sr_r       <= 1'b0;
      dis_r      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            t_fwd     <= (16'(trig_forward) > TRIG_FULL_V) ? TRIG_FULL_V : 16'(trig_forward);
            t_rev     <= (16'(trig_reverse) > TRIG_FULL_V) ? TRIG_FULL_V : 16'(trig_reverse);
            stick     <= stick_x;
            dpad_r    <= dpad;
            trim_up_r <= btn_trim_up;
            trim_dn_r <= btn_trim_down;
            step      <= STEP_FWD_MUL;
            if (!connected) begin
              if (!link_down) begin
                held_speed <= '0;
                held_steer <= '0;
                preset     <= PRESET_FULL;
              end
              link_down <= 1'b1;
              sr_r      <= 1'b0;
              dis_r     <= 1'b0;
              state     <= ST_OUT;
            end else if (awaiting_first) begin
              sr_r  <= 1'b0;
              dis_r <= 1'b0;
              state <= ST_OUT;
            end else begin
              sr_r  <= btn_self_right;
              dis_r <= btn_disable;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          step <= step + 4'd1;
          case (step)
            STEP_FWD_EST, STEP_REV_EST, STEP_STK_EST: qest <= q_hi;
            STEP_FWD_FIX: fwd  <= corr_q;
            STEP_REV_FIX: rev  <= corr_q;
            STEP_STK_FIX: qest <= tmag_dz;
            STEP_SPEED:   held_speed <= speed_val;
            STEP_STEER: begin
              held_steer <= steer_val;
              preset     <= preset_next;
              trim       <= trim_b[6:0];
              link_down  <= 1'b0;
              state      <= ST_OUT;
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (!out_valid || out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      speed_cmd      <= held_speed;
      steer_cmd      <= held_steer;
      self_right_req <= sr_r;
      disable_req    <= dis_r;
      link_up        <= !link_down;
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result word raised outside the output state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  a_preset_range: assert property (@(posedge clk) disable iff (rst)
    preset <= PRESET_FULL)
    else $error("gain preset out of range");

  a_link_down_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_up |-> speed_cmd == 0 && steer_cmd == 0)
    else $error("nonzero command word while link is down");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> step <= STEP_STEER)
    else $error("sequencer step overran");
`endif

endmodule
